@@ rtl/ads_pkg.sv @@
package ads_pkg;

    // Q1.15 unity gain
    localparam logic [15:0] UNITY = 16'h8000;

    localparam int unsigned TIMER_BITS_DEF = 16;
    localparam logic [15:0] FADE_RESET     = 16'd1000;
    localparam logic [7:0]  EFFECT_RESET   = 8'd0;

    // request opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    // sequence phases as reported
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_DUCK_IN   = 3'd1;
    localparam logic [2:0] PH_FX_BEFORE = 3'd2;
    localparam logic [2:0] PH_VOICE     = 3'd3;
    localparam logic [2:0] PH_FX_AFTER  = 3'd4;
    localparam logic [2:0] PH_DUCK_OUT  = 3'd5;

    // configuration register indexes
    localparam logic CFG_FADE   = 1'b0;
    localparam logic CFG_EFFECT = 1'b1;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [15:0] quot;
    } t_div_rsp;

endpackage

@@ rtl/ads_if.sv @@
interface ads_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [9:0]  delta_ms;
    logic [7:0]  clip_id;
    logic [15:0] duck_level;
    logic        effect_before;
    logic        effect_after;
    logic        clip_loaded;
    logic        effect_busy;
    logic        voice_busy;

    modport source (output valid, op, delta_ms, clip_id, duck_level, effect_before,
                    effect_after, clip_loaded, effect_busy, voice_busy, input ready);
    modport sink   (input valid, op, delta_ms, clip_id, duck_level, effect_before,
                    effect_after, clip_loaded, effect_busy, voice_busy, output ready);
endinterface

interface ads_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] gain;
    logic        play_effect;
    logic        play_voice;
    logic [7:0]  clip_out;
    logic        stop_all;
    logic [2:0]  phase;
    logic        start_rejected;

    modport source (output valid, gain, play_effect, play_voice, clip_out, stop_all,
                    phase, start_rejected, input ready);
    modport sink   (input valid, gain, play_effect, play_voice, clip_out, stop_all,
                    phase, start_rejected, output ready);
endinterface

@@ rtl/announcement_duck_sequencer_unit.sv @@
// Announcement ducking sequencer.
// i_req carries one request per handshake (tick, start or stop); o_res returns
// exactly one result per request: gain, play/stop pulses, clip and phase.
// Config: i_cfg_we/i_cfg_idx/i_cfg_data write fade_ms (0) and effect_clip (1);
// write only while no request is in flight.
// Sequence: start, stop, unused opcodes and non-ramp ticks go from accept
// through the emit state into the output register. A ramp tick
// (duck-in/duck-out with nonzero fade) takes these steps after accept: timer
// update, d * timer product, divider load, 16 restoring divider steps for the
// 1/F scaling, gain writeback, output register.
// Flow: one request at a time; i_req.ready is high only when the
// sequencer is idle, so the next request is taken only once the previous
// result has moved into the output register.
// Result holds in an output register; the next request is accepted while
// it waits. If o_res.ready stays low, the next result waits in the
// sequencer until the register frees, and no further request is taken.
// Reset (sync, active low): idle phase, unity gain, timer and held
// clip/level cleared, fade_ms 1000, effect_clip 0, no result pending.
module announcement_duck_sequencer_unit #(
    parameter int unsigned TIMER_BITS = ads_pkg::TIMER_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ads_req_if.sink     i_req,
    ads_res_if.source   o_res,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIVGO,
        S_DIV,
        S_EMIT
    } t_state;

    // largest timer value, for saturating the fade length
    localparam logic [32:0] TMAX = (33'd1 << TIMER_BITS) - 33'd1;

    t_state r_state;

    // configuration
    logic [15:0] r_fade;
    logic [7:0]  r_effect_clip;

    // sequence state
    logic [2:0]            r_phase;
    logic [TIMER_BITS-1:0] r_timer;
    logic [15:0]           r_held_duck;
    logic [15:0]           r_gain;
    logic [7:0]            r_held_clip;
    logic                  r_want_before;
    logic                  r_want_after;

    // ramp in flight
    logic        r_ramp_up;
    logic [31:0] r_prod;

    // pending result pulses, captured at accept
    logic       r_res_fx;
    logic       r_res_voice;
    logic [7:0] r_res_clip;
    logic       r_res_stop;
    logic       r_res_rej;

    logic       n_res_fx;
    logic       n_res_voice;
    logic [7:0] n_res_clip;
    logic       n_res_stop;
    logic       n_res_rej;

    // output register
    logic        r_out_valid;
    logic [15:0] r_out_gain;
    logic        r_out_fx;
    logic        r_out_voice;
    logic [7:0]  r_out_clip;
    logic        r_out_stop;
    logic [2:0]  r_out_phase;
    logic        r_out_rej;

    logic [15:0] w_f;
    logic [15:0] w_d;
    logic [16:0] w_sum;
    logic [15:0] w_newt;
    logic        w_f_zero;
    logic        w_ramp_done;
    logic [15:0] w_t16;
    logic [31:0] w_prod;
    logic [15:0] w_duck_sat;
    logic        w_accept;
    logic        w_ramp_tick;
    logic        w_emit;

    ads_pkg::t_div_req w_div_req;
    ads_pkg::t_div_rsp w_div_rsp;

    // effective fade: fade_ms clipped to what the timer holds
    assign w_f      = ({17'd0, r_fade} > TMAX) ? TMAX[15:0] : r_fade;
    assign w_f_zero = (w_f == 16'd0);
    // distance between unity and the duck level
    assign w_d      = ads_pkg::UNITY - r_held_duck;
    // timer never exceeds F, so 16 bits carry its value
    assign w_t16    = 16'(r_timer);
    assign w_sum    = {1'b0, w_t16} + {7'd0, i_req.delta_ms};
    assign w_newt   = (w_sum > {1'b0, w_f}) ? w_f : w_sum[15:0];
    assign w_ramp_done = w_f_zero || (w_newt == w_f);
    assign w_prod   = {16'd0, w_d} * {16'd0, w_t16};
    assign w_duck_sat = (i_req.duck_level > ads_pkg::UNITY) ? ads_pkg::UNITY
                                                             : i_req.duck_level;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && (r_state == S_IDLE);
    // tick in a ramp phase: goes through the divider unless the fade is zero
    assign w_ramp_tick = (i_req.op == ads_pkg::OP_TICK) &&
                         ((r_phase == ads_pkg::PH_DUCK_IN) ||
                          (r_phase == ads_pkg::PH_DUCK_OUT));
    // result moves into the output register this cycle
    assign w_emit      = (r_state == S_EMIT) && (!r_out_valid || o_res.ready);

    // result pulses for the request being accepted
    always_comb begin
        n_res_fx    = 1'b0;
        n_res_voice = 1'b0;
        n_res_clip  = '0;
        n_res_stop  = 1'b0;
        n_res_rej   = 1'b0;
        case (i_req.op)
            ads_pkg::OP_START: begin
                n_res_stop = 1'b1;
                n_res_rej  = !i_req.clip_loaded;
            end
            ads_pkg::OP_STOP: begin
                n_res_stop = 1'b1;
            end
            ads_pkg::OP_TICK: begin
                case (r_phase)
                    ads_pkg::PH_DUCK_IN: begin
                        if (w_ramp_done) begin
                            if (r_want_before) begin
                                n_res_fx   = 1'b1;
                                n_res_clip = r_effect_clip;
                            end else begin
                                n_res_voice = 1'b1;
                                n_res_clip  = r_held_clip;
                            end
                        end
                    end
                    ads_pkg::PH_FX_BEFORE: begin
                        if (!i_req.effect_busy) begin
                            n_res_voice = 1'b1;
                            n_res_clip  = r_held_clip;
                        end
                    end
                    ads_pkg::PH_VOICE: begin
                        if (!i_req.voice_busy && r_want_after) begin
                            n_res_fx   = 1'b1;
                            n_res_clip = r_effect_clip;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign w_div_req.start    = (r_state == S_DIVGO);
    assign w_div_req.dividend = r_prod;
    assign w_div_req.divisor  = w_f;

    ads_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_fade        <= ads_pkg::FADE_RESET;
            r_effect_clip <= ads_pkg::EFFECT_RESET;
            r_phase       <= ads_pkg::PH_IDLE;
            r_timer       <= '0;
            r_held_duck   <= '0;
            r_gain        <= ads_pkg::UNITY;
            r_held_clip   <= '0;
            r_want_before <= 1'b0;
            r_want_after  <= 1'b0;
            r_ramp_up     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ads_pkg::CFG_FADE:   r_fade        <= i_cfg_data;
                    ads_pkg::CFG_EFFECT: r_effect_clip <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            if (r_out_valid && o_res.ready && !w_emit) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_res_fx    <= n_res_fx;
                        r_res_voice <= n_res_voice;
                        r_res_clip  <= n_res_clip;
                        r_res_stop  <= n_res_stop;
                        r_res_rej   <= n_res_rej;
                        r_state     <= (w_ramp_tick && !w_f_zero) ? S_MUL : S_EMIT;
                        case (i_req.op)
                            ads_pkg::OP_START: begin
                                r_timer    <= '0;
                                r_gain     <= ads_pkg::UNITY;
                                if (!i_req.clip_loaded) begin
                                    r_phase     <= ads_pkg::PH_IDLE;
                                    r_held_clip <= '0;
                                end else begin
                                    r_held_clip   <= i_req.clip_id;
                                    r_held_duck   <= w_duck_sat;
                                    r_want_before <= i_req.effect_before;
                                    r_want_after  <= i_req.effect_after;
                                    r_phase       <= ads_pkg::PH_DUCK_IN;
                                end
                            end
                            ads_pkg::OP_STOP: begin
                                r_phase     <= ads_pkg::PH_IDLE;
                                r_timer     <= '0;
                                r_gain      <= ads_pkg::UNITY;
                                r_held_clip <= '0;
                            end
                            ads_pkg::OP_TICK: begin
                                case (r_phase)
                                    ads_pkg::PH_DUCK_IN, ads_pkg::PH_DUCK_OUT: begin
                                        r_ramp_up <= (r_phase == ads_pkg::PH_DUCK_OUT);
                                        if (w_f_zero) begin
                                            // zero fade: jump to the ramp target
                                            r_timer <= '0;
                                            r_gain  <= (r_phase == ads_pkg::PH_DUCK_IN)
                                                       ? r_held_duck : ads_pkg::UNITY;
                                        end else begin
                                            r_timer <= TIMER_BITS'(w_newt);
                                        end
                                        if (w_ramp_done) begin
                                            if (r_phase == ads_pkg::PH_DUCK_OUT) begin
                                                r_phase <= ads_pkg::PH_IDLE;
                                            end else if (r_want_before) begin
                                                r_phase <= ads_pkg::PH_FX_BEFORE;
                                            end else begin
                                                r_phase <= ads_pkg::PH_VOICE;
                                            end
                                        end
                                    end
                                    ads_pkg::PH_FX_BEFORE: begin
                                        if (!i_req.effect_busy) begin
                                            r_phase <= ads_pkg::PH_VOICE;
                                        end
                                    end
                                    ads_pkg::PH_VOICE: begin
                                        if (!i_req.voice_busy) begin
                                            if (r_want_after) begin
                                                r_phase <= ads_pkg::PH_FX_AFTER;
                                            end else begin
                                                r_timer <= '0;
                                                r_phase <= ads_pkg::PH_DUCK_OUT;
                                            end
                                        end
                                    end
                                    ads_pkg::PH_FX_AFTER: begin
                                        if (!i_req.effect_busy) begin
                                            r_timer <= '0;
                                            r_phase <= ads_pkg::PH_DUCK_OUT;
                                        end
                                    end
                                    default: ;
                                endcase
                            end
                            default: ;
                        endcase
                    end
                end
                S_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_DIVGO;
                end
                S_DIVGO: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        r_gain  <= r_ramp_up ? (r_held_duck + w_div_rsp.quot)
                                             : (ads_pkg::UNITY - w_div_rsp.quot);
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_emit) begin
                        r_out_valid <= 1'b1;
                        r_out_gain  <= r_gain;
                        r_out_fx    <= r_res_fx;
                        r_out_voice <= r_res_voice;
                        r_out_clip  <= r_res_clip;
                        r_out_stop  <= r_res_stop;
                        r_out_phase <= r_phase;
                        r_out_rej   <= r_res_rej;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.gain           = r_out_gain;
    assign o_res.play_effect    = r_out_fx;
    assign o_res.play_voice     = r_out_voice;
    assign o_res.clip_out       = r_out_clip;
    assign o_res.stop_all       = r_out_stop;
    assign o_res.phase          = r_out_phase;
    assign o_res.start_rejected = r_out_rej;

endmodule

@@ rtl/ads_div.sv @@
// Restoring divider, one quotient bit per cycle. Dividend must be below divisor * 2^16.
module ads_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ads_pkg::t_div_req i_req,
    output ads_pkg::t_div_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [3:0]  r_cnt;
    logic [15:0] r_rem;
    logic [15:0] r_low;
    logic [15:0] r_dvs;

    logic [16:0] w_shift;
    logic        w_ge;
    logic [16:0] w_diff;

    assign w_shift = {r_rem, r_low[15]};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd15;
                r_rem  <= i_req.dividend[31:16];
                r_low  <= i_req.dividend[15:0];
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[15:0] : w_shift[15:0];
                r_low <= {r_low[14:0], w_ge};
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_low;

endmodule
